FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SDCN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SDCN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sdcn_pkg.sv
// types and constants for the dot stuffing crlf normalizer
package sdcn_pkg;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam int MAX_RESULTS = 4;
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;
  } out_beat_t;

  // the bytes one input beat expands to
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [IDX_W-1:0]            last_idx;
    logic                        msg_end;
  } burst_t;

endpackage

FILE: rtl/sdcn_expand.sv
// input register, line state and expansion of one beat into a burst
module sdcn_expand (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdcn_pkg::in_beat_t in_beat,
  output logic              burst_valid,
  input  logic              burst_ready,
  output sdcn_pkg::burst_t  burst
);
  import sdcn_pkg::*;

  logic       a_valid_r;
  in_beat_t   a_beat_r;
  logic       held_cr_r, held_cr_nxt;
  logic       line_open_r, line_open_nxt;
  logic [CNT_W-1:0] n;
  logic [MAX_RESULTS-1:0][7:0] bytes;
  logic       a_move;

  always_comb begin
    logic [7:0] b;
    b             = a_beat_r.data_byte;
    n             = '0;
    bytes         = '0;
    held_cr_nxt   = held_cr_r;
    line_open_nxt = line_open_r;
    if (b == CH_LF) begin
      bytes[n[IDX_W-1:0]] = CH_CR; n = n + 1'b1;
      bytes[n[IDX_W-1:0]] = CH_LF; n = n + 1'b1;
      held_cr_nxt   = 1'b0;
      line_open_nxt = 1'b0;
    end else if (b == CH_CR) begin
      if (held_cr_r) begin
        bytes[n[IDX_W-1:0]] = CH_CR; n = n + 1'b1;
      end
      held_cr_nxt   = 1'b1;
      line_open_nxt = 1'b1;
    end else begin
      if (held_cr_r) begin
        bytes[n[IDX_W-1:0]] = CH_CR; n = n + 1'b1;
      end
      held_cr_nxt = 1'b0;
      // first byte of a line is a dot
      if (!line_open_r && b == CH_DOT) begin
        bytes[n[IDX_W-1:0]] = CH_DOT; n = n + 1'b1;
      end
      bytes[n[IDX_W-1:0]] = b; n = n + 1'b1;
      line_open_nxt = 1'b1;
    end
    if (a_beat_r.last_byte) begin
      held_cr_nxt = 1'b0;
      if (line_open_nxt) begin
        bytes[n[IDX_W-1:0]] = CH_CR; n = n + 1'b1;
        bytes[n[IDX_W-1:0]] = CH_LF; n = n + 1'b1;
      end
      line_open_nxt = 1'b0;
    end
  end

  assign burst_valid    = a_valid_r && (n != '0);
  assign burst.bytes    = bytes;
  assign burst.last_idx = IDX_W'(n - 1'b1);
  assign burst.msg_end  = a_beat_r.last_byte;

  // a beat with no output leaves without waiting
  assign a_move   = a_valid_r && ((n == '0) || burst_ready);
  assign in_ready = !a_valid_r || a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      held_cr_r   <= 1'b0;
      line_open_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (a_move) begin
        held_cr_r   <= held_cr_nxt;
        line_open_r <= line_open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_beat_r <= in_beat;
    end
  end

endmodule

FILE: rtl/sdcn_serial.sv
// burst register that hands out one byte per output beat
module sdcn_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               burst_valid,
  output logic               burst_ready,
  input  sdcn_pkg::burst_t   burst,
  output logic               out_valid,
  input  logic               out_ready,
  output sdcn_pkg::out_beat_t out_beat
);
  import sdcn_pkg::*;

  logic             s_valid_r;
  burst_t           s_burst_r;
  logic [IDX_W-1:0] idx_r;
  logic             at_end;
  logic             done;

  assign at_end      = (idx_r == s_burst_r.last_idx);
  assign done        = s_valid_r && out_ready && at_end;
  assign burst_ready = !s_valid_r || done;

  assign out_valid            = s_valid_r;
  assign out_beat.out_byte    = s_burst_r.bytes[idx_r];
  assign out_beat.run_end     = at_end;
  assign out_beat.message_end = at_end && s_burst_r.msg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      idx_r     <= '0;
    end else if (burst_valid && burst_ready) begin
      s_valid_r <= 1'b1;
      idx_r     <= '0;
    end else if (done) begin
      s_valid_r <= 1'b0;
    end else if (s_valid_r && out_ready) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      s_burst_r <= burst;
    end
  end

endmodule

FILE: rtl/smtp_dot_stuff_crlf_normalizer.sv
// a byte's first result leaves through the input register and then the output register
// throughput: one input beat per cycle while each beat gives at most one byte and out_ready
//   is high; a beat of up to 4 bytes holds the output register until its last byte is taken
// beats that give no byte leave the input register without entering the output register
// reset (rst_n low, synchronous) empties both registers and clears held cr and line state
module smtp_dot_stuff_crlf_normalizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdcn_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output sdcn_pkg::out_beat_t out_beat
);
  import sdcn_pkg::*;

  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  sdcn_expand u_expand (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  sdcn_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_beat    (out_beat)
  );

endmodule

FILE: rtl/sdcn_checker.sv
// port level checks for the normalizer and their bind
`include "assert_macros.svh"

module sdcn_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sdcn_pkg::in_beat_t  in_beat,
  input logic                out_valid,
  input logic                out_ready,
  input sdcn_pkg::out_beat_t out_beat
);
  import sdcn_pkg::*;

  // a waiting input beat holds until taken
  `SDCN_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_beat), "in beat changed while waiting")

  // a stalled result beat holds
  `SDCN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat), "out beat changed while stalled")

  // end of body always closes a burst
  `SDCN_ASSERT(a_msg_run, out_valid && out_beat.message_end |-> out_beat.run_end, "message_end without run_end")

  // every body ends on a line feed
  `SDCN_ASSERT(a_msg_lf, out_valid && out_beat.message_end |-> out_beat.out_byte == CH_LF, "body does not end in lf")

  // nothing leaves right after reset
  `SDCN_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind smtp_dot_stuff_crlf_normalizer sdcn_checker u_sdcn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
